// ===== rtl/core/fplc_pkg.sv =====
// shared types, constants and helpers for the front panel lamp controller
package fplc_pkg;

    localparam int ADDRESS_COUNT = 512;
    localparam int ADDR_W        = $clog2(ADDRESS_COUNT + 1);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int MS_W          = 32;
    localparam int PERIOD_W      = 16;
    localparam int ADDR_OUT_W    = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS    = 3'd0,
        CFG_REPEAT        = 3'd1,
        CFG_ADDR_BLINK    = 3'd2,
        CFG_SAVE_BLINK    = 3'd3,
        CFG_DOT_STEP      = 3'd4,
        CFG_COOLDOWN      = 3'd5,
        CFG_START_ADDRESS = 3'd6,
        CFG_START_COLD    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MENU_ADDRESS = 2'd1,
        MENU_LAMP    = 2'd2
    } menu_t;

    localparam logic [3:0] KEYS_RELEASED    = 4'hF;
    localparam logic [3:0] DOTS_START       = 4'h2;
    localparam logic [3:0] DOTS_ALL         = 4'hF;
    localparam logic [3:0] DOTS_NONE        = 4'h0;
    localparam logic [3:0] DOT_LEFT_END     = 4'h8;
    localparam logic [3:0] DOT_RIGHT_END    = 4'h1;
    localparam logic [3:0] SAVE_BLINK_COUNT = 4'd10;

    localparam logic [PERIOD_W-1:0] LONG_PRESS_RESET  = 16'd1000;
    localparam logic [PERIOD_W-1:0] REPEAT_RESET      = 16'd50;
    localparam logic [PERIOD_W-1:0] ADDR_BLINK_RESET  = 16'd350;
    localparam logic [PERIOD_W-1:0] SAVE_BLINK_RESET  = 16'd100;
    localparam logic [PERIOD_W-1:0] DOT_STEP_RESET    = 16'd100;
    localparam logic [MS_W-1:0]     COOLDOWN_RESET    = 32'd300000;
    localparam logic                START_COLD_RESET  = 1'b0;
    localparam logic [PERIOD_W-1:0] START_ADDR_RESET  = 16'd1;

    typedef struct packed {
        logic [PERIOD_W-1:0] long_press_ms;
        logic [PERIOD_W-1:0] repeat_ms;
        logic [PERIOD_W-1:0] address_blink_ms;
        logic [PERIOD_W-1:0] save_blink_ms;
        logic [PERIOD_W-1:0] dot_step_ms;
        logic [MS_W-1:0]     cooldown_ms;
    } timing_cfg_t;

    typedef struct packed {
        logic                addr_load;
        logic [PERIOD_W-1:0] addr_value;
        logic                cold_load;
        logic                cold_value;
    } start_load_t;

    typedef struct packed {
        logic up_edge;
        logic down_edge;
        logic enter_edge;
        logic mode_edge;
        logic up_long;
        logic down_long;
        logic enter_long;
        logic enter_released;
    } key_events_t;

    typedef struct packed {
        logic [1:0]            menu_item;
        logic                  in_submenu;
        logic                  lamp_choice;
        logic [ADDR_OUT_W-1:0] address_value;
        logic                  address_blank;
        logic                  display_on;
        logic                  store_address;
    } menu_result_t;

    typedef struct packed {
        logic [3:0] dot_pattern;
        logic       relay_on;
        logic       lamp_cold;
        logic       store_cold_flag;
    } lamp_result_t;

    function automatic logic elapsed(input logic [MS_W-1:0] now,
                                     input logic [MS_W-1:0] mark,
                                     input logic [MS_W-1:0] period);
        logic [MS_W-1:0] diff;
        diff = now - mark;
        return diff >= period;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_start(input logic [PERIOD_W-1:0] value);
        logic [ADDR_W-1:0] result;
        if (value == '0) begin
            result = ADDR_W'(ADDRESS_COUNT);
        end else if (value > PERIOD_W'(ADDRESS_COUNT)) begin
            result = ADDR_W'(1);
        end else begin
            result = value[ADDR_W-1:0];
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/fplc_keys.sv =====
// key edge and long press detection
module fplc_keys import fplc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [MS_W-1:0]     now,
    input  logic [3:0]          keys,
    input  logic [PERIOD_W-1:0] long_press_ms,
    output key_events_t         events
);

    logic [3:0]      last_keys_reg, last_keys_next;
    logic [MS_W-1:0] hold_start_reg, hold_start_next;
    logic [3:0]      edges;
    logic            held_edge;
    logic            one_held;
    logic [MS_W-1:0] hold_base;
    logic            is_long;

    assign edges = (keys ^ last_keys_reg) & ~keys;

    always_comb begin
        one_held  = 1'b1;
        held_edge = 1'b0;
        case (keys[2:0])
            3'b011: held_edge = edges[2];
            3'b110: held_edge = edges[0];
            3'b101: held_edge = edges[1];
            default: one_held = 1'b0;
        endcase
        hold_base       = held_edge ? now : hold_start_reg;
        is_long         = one_held && elapsed(now, hold_base, MS_W'(long_press_ms));
        hold_start_next = one_held ? hold_base : hold_start_reg;
        last_keys_next  = keys;
    end

    always_comb begin
        events.up_edge        = edges[0];
        events.down_edge      = edges[1];
        events.enter_edge     = edges[2];
        events.mode_edge      = edges[3];
        events.enter_long     = is_long && !keys[2];
        events.up_long        = is_long && keys[2] && !keys[0];
        events.down_long      = is_long && keys[2] && keys[0];
        events.enter_released = keys[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_keys_reg  <= KEYS_RELEASED;
            hold_start_reg <= '0;
        end else if (step) begin
            last_keys_reg  <= last_keys_next;
            hold_start_reg <= hold_start_next;
        end
    end

endmodule

// ===== rtl/core/fplc_menu.sv =====
// menu navigation, address editor and commit blink
module fplc_menu import fplc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [MS_W-1:0] now,
    input  key_events_t     events,
    input  timing_cfg_t     timing,
    input  start_load_t     start_load,
    output logic            lamp_request,
    output menu_result_t    result
);

    menu_t             menu_reg, menu_next;
    logic              edit_reg, edit_next;
    logic              choice_reg, choice_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              blank_reg, blank_next;
    logic [MS_W-1:0]   blink_mark_reg, blink_mark_next;
    logic [MS_W-1:0]   repeat_mark_reg, repeat_mark_next;
    logic [MS_W-1:0]   save_mark_reg, save_mark_next;
    logic              save_pending_reg, save_pending_next;
    logic              save_done_reg, save_done_next;
    logic [3:0]        save_blinks_reg, save_blinks_next;
    logic              enable_reg, enable_next;
    logic              lamp_req_reg, lamp_req_next;

    logic              repeat_due;
    logic              rep_up, rep_down;
    logic [1:0]        n_inc, n_dec, addr_delta;
    logic [ADDR_W:0]   addr_up;
    logic              pending_mid;
    logic              store_addr;
    logic [ADDR_W+ADDR_OUT_W-1:0] addr_ext;

    always_comb begin
        menu_next        = menu_reg;
        edit_next        = edit_reg;
        choice_next      = choice_reg;
        addr_next        = addr_reg;
        blank_next       = blank_reg;
        blink_mark_next  = blink_mark_reg;
        repeat_mark_next = repeat_mark_reg;
        save_mark_next   = save_mark_reg;
        save_done_next   = save_done_reg;
        save_blinks_next = save_blinks_reg;
        enable_next      = enable_reg;
        lamp_req_next    = lamp_req_reg;
        store_addr       = 1'b0;
        n_inc            = 2'd0;
        n_dec            = 2'd0;
        addr_delta       = 2'd0;
        addr_up          = '0;

        repeat_due = elapsed(now, repeat_mark_reg, MS_W'(timing.repeat_ms));
        rep_up     = events.up_long && repeat_due;
        rep_down   = events.down_long && repeat_due;

        case (menu_reg)
            MENU_ADDRESS: begin
                if (edit_reg) begin
                    if (events.mode_edge) begin
                        edit_next = 1'b0;
                    end
                    if (elapsed(now, blink_mark_reg, MS_W'(timing.address_blink_ms))) begin
                        blink_mark_next = now;
                        blank_next      = ~blank_reg;
                    end
                    if (rep_up || rep_down) begin
                        repeat_mark_next = now;
                    end
                    n_inc = {1'b0, events.up_edge} + {1'b0, rep_up};
                    n_dec = {1'b0, events.down_edge} + {1'b0, rep_down};
                end else begin
                    if (events.enter_edge) begin
                        edit_next = 1'b1;
                    end
                    if (events.up_edge && !events.down_edge) begin
                        menu_next = MENU_ADDRESS;
                    end else if (events.down_edge && !events.up_edge) begin
                        menu_next = MENU_LAMP;
                    end
                    blank_next = 1'b0;
                end
            end
            MENU_LAMP: begin
                if (edit_reg) begin
                    if (events.mode_edge) begin
                        edit_next = 1'b0;
                    end
                    if (events.up_edge && !events.down_edge) begin
                        choice_next = 1'b0;
                    end else if (events.down_edge && !events.up_edge) begin
                        choice_next = 1'b1;
                    end
                end else begin
                    if (events.enter_edge) begin
                        edit_next = 1'b1;
                    end
                    if (events.up_edge && !events.down_edge) begin
                        menu_next = MENU_ADDRESS;
                    end else if (events.down_edge && !events.up_edge) begin
                        menu_next = MENU_LAMP;
                    end
                end
            end
            default: ;
        endcase

        if (n_inc > n_dec) begin
            addr_delta = n_inc - n_dec;
            addr_up    = {1'b0, addr_reg} + (ADDR_W+1)'(addr_delta);
            addr_next  = (addr_up > (ADDR_W+1)'(ADDRESS_COUNT)) ? ADDR_W'(1)
                                                                 : addr_up[ADDR_W-1:0];
        end else if (n_dec > n_inc) begin
            addr_delta = n_dec - n_inc;
            addr_next  = (addr_reg <= ADDR_W'(addr_delta)) ? ADDR_W'(ADDRESS_COUNT)
                                                           : addr_reg - ADDR_W'(addr_delta);
        end

        pending_mid = save_pending_reg | (edit_next & events.enter_long);
        if (pending_mid && !save_done_reg) begin
            save_done_next = 1'b1;
            if (menu_next == MENU_LAMP) begin
                lamp_req_next = (choice_next == 1'b0);
            end else begin
                store_addr = 1'b1;
            end
        end
        if (pending_mid && (save_blinks_reg < SAVE_BLINK_COUNT)) begin
            if (elapsed(now, save_mark_reg, MS_W'(timing.save_blink_ms))) begin
                save_mark_next   = now;
                enable_next      = ~enable_reg;
                save_blinks_next = save_blinks_reg + 4'd1;
            end
        end else begin
            enable_next = 1'b1;
        end
        save_pending_next = pending_mid;
        if (events.enter_released) begin
            save_blinks_next  = 4'd0;
            save_pending_next = 1'b0;
            save_done_next    = 1'b0;
        end
    end

    assign addr_ext     = {{ADDR_OUT_W{1'b0}}, addr_next};
    assign lamp_request = lamp_req_next;

    always_comb begin
        result.menu_item     = menu_next;
        result.in_submenu    = edit_next;
        result.lamp_choice   = choice_next;
        result.address_value = addr_ext[ADDR_OUT_W-1:0];
        result.address_blank = (menu_next == MENU_ADDRESS) && blank_next;
        result.display_on    = enable_next;
        result.store_address = store_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            menu_reg         <= MENU_ADDRESS;
            edit_reg         <= 1'b0;
            choice_reg       <= 1'b0;
            addr_reg         <= wrap_start(START_ADDR_RESET);
            blank_reg        <= 1'b0;
            blink_mark_reg   <= '0;
            repeat_mark_reg  <= '0;
            save_mark_reg    <= '0;
            save_pending_reg <= 1'b0;
            save_done_reg    <= 1'b0;
            save_blinks_reg  <= 4'd0;
            enable_reg       <= 1'b1;
            lamp_req_reg     <= 1'b0;
        end else begin
            if (step) begin
                menu_reg         <= menu_next;
                edit_reg         <= edit_next;
                choice_reg       <= choice_next;
                addr_reg         <= addr_next;
                blank_reg        <= blank_next;
                blink_mark_reg   <= blink_mark_next;
                repeat_mark_reg  <= repeat_mark_next;
                save_mark_reg    <= save_mark_next;
                save_pending_reg <= save_pending_next;
                save_done_reg    <= save_done_next;
                save_blinks_reg  <= save_blinks_next;
                enable_reg       <= enable_next;
                lamp_req_reg     <= lamp_req_next;
            end
            if (start_load.addr_load) begin
                addr_reg <= wrap_start(start_load.addr_value);
            end
        end
    end

endmodule

// ===== rtl/core/fplc_lamp.sv =====
// lamp relay, cooldown timer and dot animation
module fplc_lamp import fplc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [MS_W-1:0] now,
    input  logic            lamp_request,
    input  timing_cfg_t     timing,
    input  start_load_t     start_load,
    output lamp_result_t    result
);

    logic            cold_reg, cold_next;
    logic            cooling_reg, cooling_next;
    logic [MS_W-1:0] cool_mark_reg, cool_mark_next;
    logic [MS_W-1:0] dot_mark_reg, dot_mark_next;
    logic [3:0]      dots_reg, dots_next;
    logic            dir_reg, dir_next;
    logic [3:0]      shown_reg, shown_next;
    logic            dirty_reg, dirty_next;
    logic            relay_reg, relay_next;
    logic            store_cold;
    logic            dir_step;

    assign dir_step = dir_reg ^ ((dots_reg == DOT_RIGHT_END) || (dots_reg == DOT_LEFT_END));

    always_comb begin
        cold_next      = cold_reg;
        cooling_next   = cooling_reg;
        cool_mark_next = cool_mark_reg;
        dot_mark_next  = dot_mark_reg;
        dots_next      = dots_reg;
        dir_next       = dir_reg;
        shown_next     = shown_reg;
        dirty_next     = dirty_reg;
        relay_next     = relay_reg;
        store_cold     = 1'b0;

        if (lamp_request && cooling_reg) begin
            if (elapsed(now, dot_mark_reg, MS_W'(timing.dot_step_ms))) begin
                dot_mark_next = now;
                dir_next      = dir_step;
                dots_next     = dir_step ? {dots_reg[2:0], 1'b0} : {1'b0, dots_reg[3:1]};
            end
            shown_next = dots_next;
            dirty_next = 1'b1;
        end else if (dirty_reg) begin
            dirty_next = 1'b0;
            shown_next = DOTS_NONE;
        end

        if (lamp_request && cold_reg) begin
            cold_next  = 1'b0;
            relay_next = 1'b1;
            store_cold = 1'b1;
            shown_next = DOTS_ALL;
        end else if (!lamp_request && !cold_reg && !cooling_reg) begin
            relay_next     = 1'b0;
            cool_mark_next = now;
            cooling_next   = 1'b1;
            shown_next     = DOTS_NONE;
        end

        if (cooling_next && elapsed(now, cool_mark_next, timing.cooldown_ms)) begin
            cold_next    = 1'b1;
            store_cold   = 1'b1;
            cooling_next = 1'b0;
        end
    end

    always_comb begin
        result.dot_pattern     = shown_next;
        result.relay_on        = relay_next;
        result.lamp_cold       = cold_next;
        result.store_cold_flag = store_cold;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cold_reg      <= START_COLD_RESET;
            cooling_reg   <= 1'b0;
            cool_mark_reg <= '0;
            dot_mark_reg  <= '0;
            dots_reg      <= DOTS_START;
            dir_reg       <= 1'b1;
            shown_reg     <= DOTS_NONE;
            dirty_reg     <= 1'b0;
            relay_reg     <= 1'b0;
        end else begin
            if (step) begin
                cold_reg      <= cold_next;
                cooling_reg   <= cooling_next;
                cool_mark_reg <= cool_mark_next;
                dot_mark_reg  <= dot_mark_next;
                dots_reg      <= dots_next;
                dir_reg       <= dir_next;
                shown_reg     <= shown_next;
                dirty_reg     <= dirty_next;
                relay_reg     <= relay_next;
            end
            if (start_load.cold_load) begin
                cold_reg <= start_load.cold_value;
            end
        end
    end

endmodule

// ===== rtl/core/front_panel_lamp_controller_top.sv =====
// front panel lamp controller top level: channel registers and configuration
// One tick transaction enters per clock while the pipeline is not stalled: the
// tick is captured in an input register, all key, menu and lamp updates are
// evaluated combinationally from that register, and the result lands in an
// output register that holds while the downstream side stalls, so the input
// side keeps taking a new tick every cycle as long as the result register
// drains. Configuration writes are registered; writing the start address or
// start cold flag also loads the live address or cold flag.
module front_panel_lamp_controller_top import fplc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MS_W-1:0]       s_time_ms,
    input  logic                  s_key_up,
    input  logic                  s_key_down,
    input  logic                  s_key_enter,
    input  logic                  s_key_mode,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_menu_item,
    output logic                  m_in_submenu,
    output logic                  m_lamp_choice,
    output logic [ADDR_OUT_W-1:0] m_address_value,
    output logic                  m_address_blank,
    output logic                  m_display_on,
    output logic [3:0]            m_dot_pattern,
    output logic                  m_relay_on,
    output logic                  m_lamp_cold,
    output logic                  m_store_address,
    output logic                  m_store_cold_flag,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic            in_valid_reg, in_valid_next;
    logic [MS_W-1:0] time_reg;
    logic [3:0]      keys_reg;
    logic            out_valid_reg, out_valid_next;
    menu_result_t    menu_res_reg;
    lamp_result_t    lamp_res_reg;
    timing_cfg_t     timing_reg;

    logic            advance;
    logic            in_take;
    cfg_index_t      cfg_sel;
    start_load_t     start_load;
    key_events_t     events;
    logic            lamp_request;
    menu_result_t    menu_res;
    lamp_result_t    lamp_res;

    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign in_take        = s_valid && s_ready;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);
    assign cfg_sel        = cfg_index_t'(cfg_index);

    always_comb begin
        start_load.addr_load  = 1'b0;
        start_load.addr_value = cfg_wdata[PERIOD_W-1:0];
        start_load.cold_load  = 1'b0;
        start_load.cold_value = cfg_wdata[0];
        if (cfg_wr_en) begin
            unique case (cfg_sel)
                CFG_START_ADDRESS: start_load.addr_load = 1'b1;
                CFG_START_COLD:    start_load.cold_load = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timing_reg.long_press_ms    <= LONG_PRESS_RESET;
            timing_reg.repeat_ms        <= REPEAT_RESET;
            timing_reg.address_blink_ms <= ADDR_BLINK_RESET;
            timing_reg.save_blink_ms    <= SAVE_BLINK_RESET;
            timing_reg.dot_step_ms      <= DOT_STEP_RESET;
            timing_reg.cooldown_ms      <= COOLDOWN_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_sel)
                    CFG_LONG_PRESS: timing_reg.long_press_ms    <= cfg_wdata[PERIOD_W-1:0];
                    CFG_REPEAT:     timing_reg.repeat_ms        <= cfg_wdata[PERIOD_W-1:0];
                    CFG_ADDR_BLINK: timing_reg.address_blink_ms <= cfg_wdata[PERIOD_W-1:0];
                    CFG_SAVE_BLINK: timing_reg.save_blink_ms    <= cfg_wdata[PERIOD_W-1:0];
                    CFG_DOT_STEP:   timing_reg.dot_step_ms      <= cfg_wdata[PERIOD_W-1:0];
                    CFG_COOLDOWN:   timing_reg.cooldown_ms      <= cfg_wdata[MS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            time_reg <= s_time_ms;
            keys_reg <= {s_key_mode, s_key_enter, s_key_down, s_key_up};
        end
        if (advance) begin
            menu_res_reg <= menu_res;
            lamp_res_reg <= lamp_res;
        end
    end

    fplc_keys u_keys (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .now           (time_reg),
        .keys          (keys_reg),
        .long_press_ms (timing_reg.long_press_ms),
        .events        (events)
    );

    fplc_menu u_menu (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .now          (time_reg),
        .events       (events),
        .timing       (timing_reg),
        .start_load   (start_load),
        .lamp_request (lamp_request),
        .result       (menu_res)
    );

    fplc_lamp u_lamp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .now          (time_reg),
        .lamp_request (lamp_request),
        .timing       (timing_reg),
        .start_load   (start_load),
        .result       (lamp_res)
    );

    assign m_valid           = out_valid_reg;
    assign m_menu_item       = menu_res_reg.menu_item;
    assign m_in_submenu      = menu_res_reg.in_submenu;
    assign m_lamp_choice     = menu_res_reg.lamp_choice;
    assign m_address_value   = menu_res_reg.address_value;
    assign m_address_blank   = menu_res_reg.address_blank;
    assign m_display_on      = menu_res_reg.display_on;
    assign m_store_address   = menu_res_reg.store_address;
    assign m_dot_pattern     = lamp_res_reg.dot_pattern;
    assign m_relay_on        = lamp_res_reg.relay_on;
    assign m_lamp_cold       = lamp_res_reg.lamp_cold;
    assign m_store_cold_flag = lamp_res_reg.store_cold_flag;

endmodule

// ===== rtl/core/fplc_checker.sv =====
// port-level checks for the front panel lamp controller, bound to the top level
module fplc_checker import fplc_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [MS_W-1:0]       s_time_ms,
    input logic                  s_key_up,
    input logic                  s_key_down,
    input logic                  s_key_enter,
    input logic                  s_key_mode,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_menu_item,
    input logic                  m_in_submenu,
    input logic                  m_lamp_choice,
    input logic [ADDR_OUT_W-1:0] m_address_value,
    input logic                  m_address_blank,
    input logic                  m_display_on,
    input logic [3:0]            m_dot_pattern,
    input logic                  m_relay_on,
    input logic                  m_lamp_cold,
    input logic                  m_store_address,
    input logic                  m_store_cold_flag,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    // stalled result transaction holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_address_value)
            && $stable(m_dot_pattern) && $stable(m_store_cold_flag))
        else $error("result changed while stalled");

    a_menu_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_menu_item == MENU_ADDRESS) || (m_menu_item == MENU_LAMP))
        else $error("menu item out of range");

    a_blank_only_address: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_menu_item == MENU_LAMP) |-> !m_address_blank)
        else $error("address blanked outside address item");

    a_store_addr_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_store_address |-> (m_menu_item == MENU_ADDRESS) && m_in_submenu)
        else $error("address store outside address editor");

endmodule

bind front_panel_lamp_controller_top fplc_checker u_fplc_checker (.*);

// ===== dv/front_panel_lamp_controller_top_test.sv =====
// self-checking testbench for the front panel lamp controller top level
`timescale 1ns / 1ps

module front_panel_lamp_controller_top_test;
    import fplc_pkg::*;

    localparam int         PHASES          = 6;
    localparam int         TICKS_PER_PHASE = 200;
    localparam logic [3:0] PRESS_UP        = 4'hE;
    localparam logic [3:0] PRESS_DOWN      = 4'hD;
    localparam logic [3:0] PRESS_UPDOWN    = 4'hC;
    localparam logic [3:0] PRESS_ENTER     = 4'hB;
    localparam logic [3:0] PRESS_MODE      = 4'h7;
    localparam logic [3:0] PRESS_ALL       = 4'h0;

    typedef struct packed {
        logic [1:0]            menu_item;
        logic                  in_submenu;
        logic                  lamp_choice;
        logic [ADDR_OUT_W-1:0] address_value;
        logic                  address_blank;
        logic                  display_on;
        logic [3:0]            dot_pattern;
        logic                  relay_on;
        logic                  lamp_cold;
        logic                  store_address;
        logic                  store_cold_flag;
    } panel_t;

    typedef struct packed {
        logic [MS_W-1:0]       t;
        logic [3:0]            keys;
        logic                  pinned;
        logic [1:0]            menu;
        logic                  sub;
        logic [ADDR_OUT_W-1:0] addr;
    } tick_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [MS_W-1:0]       s_time_ms;
    logic                  s_key_up;
    logic                  s_key_down;
    logic                  s_key_enter;
    logic                  s_key_mode;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_menu_item;
    logic                  m_in_submenu;
    logic                  m_lamp_choice;
    logic [ADDR_OUT_W-1:0] m_address_value;
    logic                  m_address_blank;
    logic                  m_display_on;
    logic [3:0]            m_dot_pattern;
    logic                  m_relay_on;
    logic                  m_lamp_cold;
    logic                  m_store_address;
    logic                  m_store_cold_flag;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    front_panel_lamp_controller_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_ms         (s_time_ms),
        .s_key_up          (s_key_up),
        .s_key_down        (s_key_down),
        .s_key_enter       (s_key_enter),
        .s_key_mode        (s_key_mode),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_menu_item       (m_menu_item),
        .m_in_submenu      (m_in_submenu),
        .m_lamp_choice     (m_lamp_choice),
        .m_address_value   (m_address_value),
        .m_address_blank   (m_address_blank),
        .m_display_on      (m_display_on),
        .m_dot_pattern     (m_dot_pattern),
        .m_relay_on        (m_relay_on),
        .m_lamp_cold       (m_lamp_cold),
        .m_store_address   (m_store_address),
        .m_store_cold_flag (m_store_cold_flag),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    // panel model configuration
    logic [PERIOD_W-1:0] long_press_ms, repeat_ms, address_blink_ms;
    logic [PERIOD_W-1:0] save_blink_ms, dot_step_ms, start_address;
    logic [MS_W-1:0]     cooldown_ms;
    logic                start_cold;

    // panel model state
    logic [3:0]      last_keys, save_blinks, bounce_dots, dots_shown;
    logic [MS_W-1:0] hold_start, repeat_mark, blink_mark, save_mark, dot_mark, cool_mark;
    int              menu_pos, choice_pos, address_reg;
    logic            editing, blank_flag, save_pending, save_done, display_en;
    logic            lamp_request, cold_flag, cooling, bounce_left, dots_dirty, relay_state;

    panel_t      expected_panel [$];
    int unsigned mismatches = 0;
    int unsigned ticks_sent = 0;
    int unsigned address_saves = 0;
    int unsigned cold_saves = 0;
    bit          steady_run = 1'b0;
    logic [MS_W-1:0] clock_ms;

    tick_row_t warmup_script [27] = '{
        '{32'd0,    KEYS_RELEASED, 1'b1, MENU_ADDRESS, 1'b0, 10'd1},
        '{32'd10,   PRESS_ENTER,   1'b1, MENU_ADDRESS, 1'b1, 10'd1},
        '{32'd20,   KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd30,   PRESS_DOWN,    1'b1, MENU_ADDRESS, 1'b1, 10'd512},
        '{32'd40,   KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd50,   PRESS_UP,      1'b1, MENU_ADDRESS, 1'b1, 10'd1},
        '{32'd60,   KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd70,   PRESS_UPDOWN,  1'b1, MENU_ADDRESS, 1'b1, 10'd1},
        '{32'd80,   KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd90,   PRESS_UP,      1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd1090, PRESS_UP,      1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd1100, KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd1110, PRESS_ENTER,   1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2110, PRESS_ENTER,   1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2300, PRESS_ENTER,   1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2400, KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2410, PRESS_MODE,    1'b1, MENU_ADDRESS, 1'b0, 10'd3},
        '{32'd2420, KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2430, PRESS_DOWN,    1'b1, MENU_LAMP,    1'b0, 10'd3},
        '{32'd2440, KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2450, PRESS_DOWN,    1'b1, MENU_LAMP,    1'b0, 10'd3},
        '{32'd2460, KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2470, PRESS_ENTER,   1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2480, KEYS_RELEASED, 1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd2490, PRESS_ENTER,   1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'd3490, PRESS_ENTER,   1'b0, MENU_ADDRESS, 1'b0, 10'd0},
        '{32'hFFFF_FFFF, PRESS_ALL, 1'b0, MENU_ADDRESS, 1'b0, 10'd0}
    };

    function automatic bit timer_due(input logic [MS_W-1:0] now, input logic [MS_W-1:0] mark,
                                     input logic [MS_W-1:0] period);
        logic [MS_W-1:0] gap;
        gap = now - mark;
        return gap >= period;
    endfunction

    function automatic int wrap_address(input int a);
        if (a < 1) return ADDRESS_COUNT;
        if (a > ADDRESS_COUNT) return 1;
        return a;
    endfunction

    task automatic advance_panel(input logic [MS_W-1:0] now, input logic [3:0] keys,
                                 output panel_t res);
        logic       up, dn, en, md, up_e, dn_e, en_e, md_e, up_l, dn_l, en_l;
        logic       st_addr, st_cold;
        logic [3:0] changed;
        up = keys[0];
        dn = keys[1];
        en = keys[2];
        md = keys[3];
        changed = keys ^ last_keys;
        up_e = changed[0] & ~up;
        dn_e = changed[1] & ~dn;
        en_e = changed[2] & ~en;
        md_e = changed[3] & ~md;
        up_l = 1'b0;
        dn_l = 1'b0;
        en_l = 1'b0;
        st_addr = 1'b0;
        st_cold = 1'b0;
        last_keys = keys;

        // long press only with exactly one of up, down, enter held
        if ({1'b0, up} + {1'b0, dn} + {1'b0, en} == 2'd2) begin
            if (!en) begin
                if (en_e) hold_start = now;
                en_l = timer_due(now, hold_start, long_press_ms);
            end else if (!up) begin
                if (up_e) hold_start = now;
                up_l = timer_due(now, hold_start, long_press_ms);
            end else begin
                if (dn_e) hold_start = now;
                dn_l = timer_due(now, hold_start, long_press_ms);
            end
        end

        if (menu_pos == int'(MENU_ADDRESS)) begin
            if (editing) begin
                if (md_e) editing = 1'b0;
                if (up_e) address_reg++;
                if (dn_e) address_reg--;
                if (timer_due(now, blink_mark, address_blink_ms)) begin
                    blink_mark = now;
                    blank_flag = ~blank_flag;
                end
                if (up_l && timer_due(now, repeat_mark, repeat_ms)) begin
                    repeat_mark = now;
                    address_reg++;
                end
                if (dn_l && timer_due(now, repeat_mark, repeat_ms)) begin
                    repeat_mark = now;
                    address_reg--;
                end
            end else begin
                if (en_e) editing = 1'b1;
                if (up_e) menu_pos--;
                if (dn_e) menu_pos++;
                blank_flag = 1'b0;
            end
        end else if (menu_pos == int'(MENU_LAMP)) begin
            if (editing) begin
                if (md_e) editing = 1'b0;
                if (up_e) choice_pos--;
                if (dn_e) choice_pos++;
            end else begin
                if (en_e) editing = 1'b1;
                if (up_e) menu_pos--;
                if (dn_e) menu_pos++;
            end
        end
        if (menu_pos < int'(MENU_ADDRESS)) menu_pos = int'(MENU_ADDRESS);
        if (menu_pos > int'(MENU_LAMP)) menu_pos = int'(MENU_LAMP);
        if (choice_pos < 0) choice_pos = 0;
        if (choice_pos > 1) choice_pos = 1;
        address_reg = wrap_address(address_reg);

        // commit once per enter hold
        if (editing && en_l) save_pending = 1'b1;
        if (save_pending && !save_done) begin
            save_done = 1'b1;
            if (menu_pos == int'(MENU_LAMP)) lamp_request = (choice_pos == 0);
            else st_addr = 1'b1;
        end
        if (save_pending && save_blinks < SAVE_BLINK_COUNT) begin
            if (timer_due(now, save_mark, save_blink_ms)) begin
                save_mark = now;
                display_en = ~display_en;
                save_blinks++;
            end
        end else begin
            display_en = 1'b1;
        end
        if (en) begin
            save_blinks = '0;
            save_pending = 1'b0;
            save_done = 1'b0;
        end

        if (lamp_request && cooling) begin
            if (timer_due(now, dot_mark, dot_step_ms)) begin
                dot_mark = now;
                if (bounce_dots == DOT_RIGHT_END || bounce_dots == DOT_LEFT_END) begin
                    bounce_left = ~bounce_left;
                end
                if (bounce_left) bounce_dots = bounce_dots << 1;
                else bounce_dots = bounce_dots >> 1;
            end
            dots_shown = bounce_dots;
            dots_dirty = 1'b1;
        end else if (dots_dirty) begin
            dots_dirty = 1'b0;
            dots_shown = DOTS_NONE;
        end

        if (lamp_request && cold_flag) begin
            cold_flag = 1'b0;
            relay_state = 1'b1;
            st_cold = 1'b1;
            dots_shown = DOTS_ALL;
        end else if (!lamp_request && !cold_flag && !cooling) begin
            relay_state = 1'b0;
            cool_mark = now;
            cooling = 1'b1;
            dots_shown = DOTS_NONE;
        end
        if (cooling && timer_due(now, cool_mark, cooldown_ms)) begin
            cold_flag = 1'b1;
            st_cold = 1'b1;
            cooling = 1'b0;
        end

        res.menu_item = 2'(menu_pos);
        res.in_submenu = editing;
        res.lamp_choice = choice_pos[0];
        res.address_value = ADDR_OUT_W'(address_reg);
        res.address_blank = (menu_pos == int'(MENU_ADDRESS)) ? blank_flag : 1'b0;
        res.display_on = display_en;
        res.dot_pattern = dots_shown;
        res.relay_on = relay_state;
        res.lamp_cold = cold_flag;
        res.store_address = st_addr;
        res.store_cold_flag = st_cold;
    endtask

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic send_tick(input tick_row_t row);
        panel_t want;
        while (!steady_run && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_time_ms <= row.t;
        s_key_up <= row.keys[0];
        s_key_down <= row.keys[1];
        s_key_enter <= row.keys[2];
        s_key_mode <= row.keys[3];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_panel(row.t, row.keys, want);
        if (row.pinned) begin
            want.menu_item = row.menu;
            want.in_submenu = row.sub;
            want.address_value = row.addr;
        end
        expected_panel.push_back(want);
        ticks_sent++;
        address_saves += want.store_address;
        cold_saves += want.store_cold_flag;
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_LONG_PRESS:    long_press_ms = data[PERIOD_W-1:0];
            CFG_REPEAT:        repeat_ms = data[PERIOD_W-1:0];
            CFG_ADDR_BLINK:    address_blink_ms = data[PERIOD_W-1:0];
            CFG_SAVE_BLINK:    save_blink_ms = data[PERIOD_W-1:0];
            CFG_DOT_STEP:      dot_step_ms = data[PERIOD_W-1:0];
            CFG_COOLDOWN:      cooldown_ms = data;
            CFG_START_ADDRESS: begin
                start_address = data[PERIOD_W-1:0];
                address_reg = wrap_address(int'(start_address));
            end
            CFG_START_COLD: begin
                start_cold = data[0];
                cold_flag = data[0];
            end
            default: ;
        endcase
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_panel.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= steady_run || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge aclk) begin : check_results
        panel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_panel.size() == 0) begin
                report_mismatch("transaction with nothing expected", 1, 0);
            end else begin
                want = expected_panel.pop_front();
                if (m_menu_item != want.menu_item)
                    report_mismatch("menu_item", m_menu_item, want.menu_item);
                if (m_in_submenu != want.in_submenu)
                    report_mismatch("in_submenu", m_in_submenu, want.in_submenu);
                if (m_lamp_choice != want.lamp_choice)
                    report_mismatch("lamp_choice", m_lamp_choice, want.lamp_choice);
                if (m_address_value != want.address_value)
                    report_mismatch("address_value", m_address_value, want.address_value);
                if (m_address_blank != want.address_blank)
                    report_mismatch("address_blank", m_address_blank, want.address_blank);
                if (m_display_on != want.display_on)
                    report_mismatch("display_on", m_display_on, want.display_on);
                if (m_dot_pattern != want.dot_pattern)
                    report_mismatch("dot_pattern", m_dot_pattern, want.dot_pattern);
                if (m_relay_on != want.relay_on)
                    report_mismatch("relay_on", m_relay_on, want.relay_on);
                if (m_lamp_cold != want.lamp_cold)
                    report_mismatch("lamp_cold", m_lamp_cold, want.lamp_cold);
                if (m_store_address != want.store_address)
                    report_mismatch("store_address", m_store_address, want.store_address);
                if (m_store_cold_flag != want.store_cold_flag)
                    report_mismatch("store_cold_flag", m_store_cold_flag, want.store_cold_flag);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("front_panel_lamp_controller_top_test: done, errors");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] reg_value [8];
        logic [CFG_DATA_W-1:0] junk, data;
        logic [3:0]            held;
        tick_row_t             row;
        int unsigned           pick, hold, rest, max_step, phase_ticks;
        bit                    noisy;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_time_ms <= '0;
        s_key_up <= 1'b1;
        s_key_down <= 1'b1;
        s_key_enter <= 1'b1;
        s_key_mode <= 1'b1;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_LONG_PRESS;
        cfg_wdata <= '0;

        long_press_ms = LONG_PRESS_RESET;
        repeat_ms = REPEAT_RESET;
        address_blink_ms = ADDR_BLINK_RESET;
        save_blink_ms = SAVE_BLINK_RESET;
        dot_step_ms = DOT_STEP_RESET;
        cooldown_ms = COOLDOWN_RESET;
        start_address = START_ADDR_RESET;
        start_cold = START_COLD_RESET;
        last_keys = KEYS_RELEASED;
        hold_start = '0;
        repeat_mark = '0;
        blink_mark = '0;
        save_mark = '0;
        dot_mark = '0;
        cool_mark = '0;
        menu_pos = int'(MENU_ADDRESS);
        editing = 1'b0;
        choice_pos = 0;
        address_reg = wrap_address(int'(start_address));
        blank_flag = 1'b0;
        save_pending = 1'b0;
        save_done = 1'b0;
        save_blinks = '0;
        display_en = 1'b1;
        lamp_request = 1'b0;
        cold_flag = start_cold;
        cooling = 1'b0;
        bounce_dots = DOTS_START;
        bounce_left = 1'b1;
        dots_shown = DOTS_NONE;
        dots_dirty = 1'b0;
        relay_state = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (warmup_script[i]) send_tick(warmup_script[i]);
        clock_ms = warmup_script[26].t;

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_results();
            steady_run = (phase == 2);
            case (phase)
                0: begin
                    reg_value = '{32'd20, 32'd5, 32'd30, 32'd5, 32'd10, 32'd300,
                                  $urandom_range(0, 600), $urandom_range(0, 1)};
                    max_step = 10;
                end
                1: begin
                    reg_value = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd1};
                    max_step = 3;
                end
                2: begin
                    reg_value = '{32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                  32'hFFFF_FFFF, 32'hFFFF, 32'd0};
                    max_step = 30000;
                end
                3: begin
                    reg_value = '{$urandom_range(1, 200), $urandom_range(1, 200),
                                  $urandom_range(1, 200), $urandom_range(1, 200),
                                  $urandom_range(1, 200), $urandom_range(1, 2000),
                                  $urandom_range(0, 65535), $urandom_range(0, 1)};
                    max_step = 40;
                    clock_ms = 32'hFFFF_FF00;
                end
                4: begin
                    reg_value = '{32'd15, 32'd3, 32'd20, 32'd4, 32'd8, 32'd150, 32'd513, 32'd1};
                    max_step = 8;
                end
                default: begin
                    reg_value = '{32'd1000, 32'd50, 32'd350, 32'd100, 32'd100, 32'd3000,
                                  32'd512, 32'd0};
                    max_step = 400;
                end
            endcase
            // unused upper bits of the write data carry random junk
            for (int r = 0; r < 8; r++) begin
                junk = $urandom();
                if (cfg_index_t'(r) == CFG_START_COLD) data = {junk[31:1], reg_value[r][0]};
                else if (cfg_index_t'(r) == CFG_COOLDOWN) data = reg_value[r];
                else data = {junk[31:16], reg_value[r][15:0]};
                write_register(cfg_index_t'(r), data);
            end
            cfg_wr_en <= 1'b0;
            @(posedge aclk);

            phase_ticks = 0;
            row.pinned = 1'b0;
            row.menu = MENU_ADDRESS;
            row.sub = 1'b0;
            row.addr = '0;
            while (phase_ticks < TICKS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                noisy = 1'b0;
                held = KEYS_RELEASED;
                if (pick < 30) held = PRESS_ENTER;
                else if (pick < 50) held = PRESS_UP;
                else if (pick < 70) held = PRESS_DOWN;
                else if (pick < 85) held = PRESS_MODE;
                else if (pick < 95) held = 4'($urandom()) & 4'($urandom());
                else noisy = 1'b1;
                hold = ($urandom_range(0, 99) < 30) ? $urandom_range(5, 40) : $urandom_range(1, 4);
                rest = $urandom_range(1, 4);
                for (int n = 0; n < hold + rest; n++) begin
                    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
                    else clock_ms = clock_ms + $urandom_range(0, max_step);
                    row.t = clock_ms;
                    if (n >= hold) row.keys = KEYS_RELEASED;
                    else if (noisy) row.keys = 4'($urandom());
                    else row.keys = held;
                    send_tick(row);
                end
                phase_ticks += hold + rest;
            end
        end
        steady_run = 1'b0;
        wait_for_results();

        $display("ticks checked: %0d over %0d register settings", ticks_sent, PHASES + 1);
        $display("address saves: %0d, cold flag saves: %0d, mismatches: %0d",
                 address_saves, cold_saves, mismatches);
        if (mismatches == 0) begin
            $display("front_panel_lamp_controller_top_test: done, clean");
        end else begin
            $display("front_panel_lamp_controller_top_test: done, errors");
        end
        $finish;
    end

endmodule
